>>> rtl/core/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants of the chunked provision stager
// Item capacities, staging layout, status and request codes, and the request
// and acknowledgement records passed between the stager's stages.
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

    localparam int unsigned NUM_ITEMS      = 10;
    localparam int unsigned IDX_W          = 4;
    localparam int unsigned FILL_W         = 12;
    localparam int unsigned ADDR_W         = 13;
    localparam int unsigned KEYLEN_W       = 7;
    localparam int unsigned REQUIRED_ITEMS = 7;
    localparam int unsigned S_TDATA_W      = 64;
    localparam int unsigned M_TDATA_W      = 40;

    // Per-item byte capacities.
    localparam int unsigned SSID_MAX        = 32;
    localparam int unsigned KEY_PHRASE_MAX  = 64;
    localparam int unsigned HOST_MAX        = 64;
    localparam int unsigned PORT_LEN        = 2;
    localparam int unsigned CA_CERT_MAX     = 2048;
    localparam int unsigned CLIENT_CERT_MAX = 2048;
    localparam int unsigned CLIENT_KEY_MAX  = 2048;

    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam fill_t ITEM_CAP [NUM_ITEMS] = '{
        FILL_W'(SSID_MAX), FILL_W'(KEY_PHRASE_MAX), FILL_W'(HOST_MAX),
        FILL_W'(PORT_LEN), FILL_W'(CA_CERT_MAX), FILL_W'(CLIENT_CERT_MAX),
        FILL_W'(CLIENT_KEY_MAX), FILL_W'(0), FILL_W'(0), FILL_W'(HOST_MAX)
    };

    // Staging base of each item: running sum of the capacities before it.
    localparam int unsigned BASE_1 = SSID_MAX;
    localparam int unsigned BASE_2 = BASE_1 + KEY_PHRASE_MAX;
    localparam int unsigned BASE_3 = BASE_2 + HOST_MAX;
    localparam int unsigned BASE_4 = BASE_3 + PORT_LEN;
    localparam int unsigned BASE_5 = BASE_4 + CA_CERT_MAX;
    localparam int unsigned BASE_6 = BASE_5 + CLIENT_CERT_MAX;
    localparam int unsigned BASE_7 = BASE_6 + CLIENT_KEY_MAX;

    localparam addr_t ITEM_BASE [NUM_ITEMS] = '{
        ADDR_W'(0), ADDR_W'(BASE_1), ADDR_W'(BASE_2), ADDR_W'(BASE_3),
        ADDR_W'(BASE_4), ADDR_W'(BASE_5), ADDR_W'(BASE_6), ADDR_W'(BASE_7),
        ADDR_W'(BASE_7), ADDR_W'(BASE_7)
    };

    localparam addr_t PORT_BASE_LO = ADDR_W'(BASE_3);
    localparam addr_t PORT_BASE_HI = ADDR_W'(BASE_3 + 1);

    localparam logic [IDX_W-1:0] KEY_IDX  = IDX_W'(1);
    localparam logic [IDX_W-1:0] PORT_IDX = IDX_W'(3);

    localparam logic [7:0] ITEM_FIRST  = 8'd1;
    localparam logic [7:0] ITEM_COMMIT = 8'd8;
    localparam logic [7:0] ITEM_WIPE   = 8'd9;
    localparam logic [7:0] ITEM_LAST   = 8'd10;

    localparam logic [KEYLEN_W-1:0] MIN_KEY_RESET = KEYLEN_W'(8);

    typedef enum logic
    {
        ACT_HEADER = 1'b0,
        ACT_DATA   = 1'b1
    } action_t;

    typedef enum logic [2:0]
    {
        ST_OK     = 3'd0,
        ST_FORMAT = 3'd1,
        ST_WIFI   = 3'd2,
        ST_COMMIT = 3'd3,
        ST_CRYPTO = 3'd4,
        ST_FLASH  = 3'd5,
        ST_OFFSET = 3'd6
    } status_t;

    typedef enum logic [1:0]
    {
        REQ_NONE   = 2'd0,
        REQ_COMMIT = 2'd1,
        REQ_WIPE   = 2'd2
    } store_req_t;

    typedef struct packed
    {
        action_t     action;
        logic [7:0]  item_id;
        logic [7:0]  generation;
        logic [15:0] offset;
        logic [15:0] data_len;
        logic [7:0]  data_byte;
        logic        format_ok;
        logic        on_wifi;
        logic        flash_ok;
        logic        crypto_ok;
    } request_t;

    // Declared high field first so that ack_item lands in the lowest bits.
    typedef struct packed
    {
        store_req_t  store_request;
        fill_t       next_offset;
        status_t     ack_status;
        logic [7:0]  ack_generation;
        logic [7:0]  ack_item;
    } ack_t;

endpackage

`default_nettype wire

>>> rtl/core/cps_in_stage.sv
// ----------------------------------------------------------------------------
// cps_in_stage: input register of the stager
// Captures one request from the slave stream and holds it until the session
// stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_in_stage
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [cps_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           advance,
    output      logic                           req_valid,
    output      cps_pkg::request_t              req
);

    logic              valid_reg;
    logic              valid_next;
    cps_pkg::request_t req_reg;
    logic              load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg.action     <= cps_pkg::action_t'(s_tuser);
            req_reg.item_id    <= s_tdata[7:0];
            req_reg.generation <= s_tdata[15:8];
            req_reg.offset     <= s_tdata[31:16];
            req_reg.data_len   <= s_tdata[47:32];
            req_reg.data_byte  <= s_tdata[55:48];
            req_reg.format_ok  <= s_tdata[56];
            req_reg.on_wifi    <= s_tdata[57];
            req_reg.flash_ok   <= s_tdata[58];
            req_reg.crypto_ok  <= s_tdata[59];
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

>>> rtl/core/cps_session.sv
// ----------------------------------------------------------------------------
// cps_session: session state and per-request decision logic
// Holds fill levels, session generation, port shadow and the data write
// cursor; answers each header, advances the cursor on each pending data byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_session
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [cps_pkg::KEYLEN_W-1:0]   cfg_wdata,
    input  wire logic                            fire,
    input  wire cps_pkg::request_t               req,
    output      logic                            ack_valid,
    output      cps_pkg::ack_t                   ack
);

    logic                          open_reg, open_next;
    logic [7:0]                    gen_reg, gen_next;
    cps_pkg::fill_t                fill_reg [cps_pkg::NUM_ITEMS];
    cps_pkg::fill_t                fill_next [cps_pkg::NUM_ITEMS];
    logic [15:0]                   port_reg, port_next;
    cps_pkg::addr_t                wptr_reg, wptr_next;
    cps_pkg::fill_t                pend_reg, pend_next;
    logic                          wallow_reg, wallow_next;
    logic [cps_pkg::KEYLEN_W-1:0]  min_key_reg;

    logic [cps_pkg::IDX_W-1:0]     idx;
    logic                          new_session;
    logic                          item_known;
    logic                          ctrl_args_bad;
    logic                          fills_present;
    logic                          set_valid;
    cps_pkg::fill_t                cur_fill;
    logic [16:0]                   chunk_end;
    cps_pkg::fill_t                pend_dec;

    assign idx         = cps_pkg::IDX_W'(req.item_id[cps_pkg::IDX_W-1:0] - 4'd1);
    assign new_session = !open_reg || (req.generation != gen_reg);
    assign item_known  = (req.item_id >= cps_pkg::ITEM_FIRST)
                      && (req.item_id <= cps_pkg::ITEM_LAST);
    assign ctrl_args_bad = (req.offset != 16'd0) || (req.data_len != 16'd0);
    assign chunk_end   = {1'b0, req.offset} + {1'b0, req.data_len};
    assign pend_dec    = pend_reg - cps_pkg::FILL_W'(1);

    // Staged set is complete: all required items present, key long enough,
    // port fully written and nonzero.
    always_comb
    begin
        fills_present = 1'b1;
        for (int i = 0; i < cps_pkg::REQUIRED_ITEMS; i++)
        begin
            if (fill_reg[i] == '0)
            begin
                fills_present = 1'b0;
            end
        end
        set_valid = fills_present
                 && (fill_reg[cps_pkg::KEY_IDX] >= {5'b0, min_key_reg})
                 && (fill_reg[cps_pkg::PORT_IDX] == cps_pkg::FILL_W'(cps_pkg::PORT_LEN))
                 && (port_reg != 16'd0);
    end

    always_comb
    begin
        open_next   = open_reg;
        gen_next    = gen_reg;
        fill_next   = fill_reg;
        port_next   = port_reg;
        wptr_next   = wptr_reg;
        pend_next   = pend_reg;
        wallow_next = wallow_reg;
        cur_fill    = '0;

        ack_valid            = 1'b0;
        ack.ack_item         = req.item_id;
        ack.ack_generation   = req.generation;
        ack.ack_status       = cps_pkg::ST_OK;
        ack.next_offset      = '0;
        ack.store_request    = cps_pkg::REQ_NONE;

        if (fire)
        begin
            if (req.action == cps_pkg::ACT_DATA)
            begin
                if (wallow_reg && (pend_reg != '0))
                begin
                    if (wptr_reg == cps_pkg::PORT_BASE_LO)
                    begin
                        port_next = {port_reg[15:8], req.data_byte};
                    end
                    else if (wptr_reg == cps_pkg::PORT_BASE_HI)
                    begin
                        port_next = {req.data_byte, port_reg[7:0]};
                    end
                    wptr_next = wptr_reg + cps_pkg::ADDR_W'(1);
                    pend_next = pend_dec;
                    if (pend_dec == '0)
                    begin
                        wallow_next = 1'b0;
                    end
                end
            end
            else
            begin
                ack_valid   = 1'b1;
                wallow_next = 1'b0;
                pend_next   = '0;

                if (!req.format_ok)
                begin
                    ack.ack_status = cps_pkg::ST_FORMAT;
                end
                else if (req.on_wifi)
                begin
                    ack.ack_status = cps_pkg::ST_WIFI;
                end
                else if (req.item_id == cps_pkg::ITEM_WIPE)
                begin
                    if (ctrl_args_bad)
                    begin
                        ack.ack_status = cps_pkg::ST_FORMAT;
                    end
                    else
                    begin
                        open_next = 1'b0;
                        gen_next  = '0;
                        for (int i = 0; i < cps_pkg::NUM_ITEMS; i++)
                        begin
                            fill_next[i] = '0;
                        end
                        port_next         = '0;
                        wptr_next         = '0;
                        ack.store_request = cps_pkg::REQ_WIPE;
                        ack.ack_status    = req.flash_ok ? cps_pkg::ST_OK : cps_pkg::ST_FLASH;
                    end
                end
                else if (req.item_id == cps_pkg::ITEM_COMMIT)
                begin
                    if (ctrl_args_bad)
                    begin
                        ack.ack_status = cps_pkg::ST_FORMAT;
                    end
                    else if (new_session || !set_valid)
                    begin
                        ack.ack_status = cps_pkg::ST_COMMIT;
                    end
                    else if (!req.crypto_ok)
                    begin
                        ack.ack_status = cps_pkg::ST_CRYPTO;
                    end
                    else
                    begin
                        ack.store_request = cps_pkg::REQ_COMMIT;
                        if (req.flash_ok)
                        begin
                            open_next = 1'b0;
                            gen_next  = '0;
                            for (int i = 0; i < cps_pkg::NUM_ITEMS; i++)
                            begin
                                fill_next[i] = '0;
                            end
                            port_next = '0;
                            wptr_next = '0;
                        end
                        else
                        begin
                            ack.ack_status = cps_pkg::ST_FLASH;
                        end
                    end
                end
                else if (!item_known)
                begin
                    ack.ack_status = cps_pkg::ST_FORMAT;
                end
                else
                begin
                    // A new generation opens a fresh session with empty items.
                    if (new_session)
                    begin
                        for (int i = 0; i < cps_pkg::NUM_ITEMS; i++)
                        begin
                            fill_next[i] = '0;
                        end
                        gen_next  = req.generation;
                        open_next = 1'b1;
                    end
                    // Offset zero restarts the item.
                    if (new_session || (req.offset == 16'd0))
                    begin
                        cur_fill = '0;
                    end
                    else
                    begin
                        cur_fill = fill_reg[idx];
                    end
                    fill_next[idx] = cur_fill;

                    if (req.offset != {4'b0, cur_fill})
                    begin
                        // Gap is a mismatch; a retransmit just re-acks.
                        ack.ack_status = (req.offset > {4'b0, cur_fill})
                                       ? cps_pkg::ST_OFFSET : cps_pkg::ST_OK;
                        ack.next_offset = cur_fill;
                    end
                    else if (chunk_end > {5'b0, cps_pkg::ITEM_CAP[idx]})
                    begin
                        ack.ack_status  = cps_pkg::ST_FORMAT;
                        ack.next_offset = cur_fill;
                    end
                    else
                    begin
                        wptr_next = cps_pkg::ITEM_BASE[idx]
                                  + req.offset[cps_pkg::ADDR_W-1:0];
                        pend_next      = req.data_len[cps_pkg::FILL_W-1:0];
                        wallow_next    = (req.data_len != 16'd0);
                        fill_next[idx] = chunk_end[cps_pkg::FILL_W-1:0];
                        ack.next_offset = chunk_end[cps_pkg::FILL_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            gen_reg     <= '0;
            for (int i = 0; i < cps_pkg::NUM_ITEMS; i++)
            begin
                fill_reg[i] <= '0;
            end
            port_reg    <= '0;
            wptr_reg    <= '0;
            pend_reg    <= '0;
            wallow_reg  <= 1'b0;
            min_key_reg <= cps_pkg::MIN_KEY_RESET;
        end
        else
        begin
            open_reg   <= open_next;
            gen_reg    <= gen_next;
            fill_reg   <= fill_next;
            port_reg   <= port_next;
            wptr_reg   <= wptr_next;
            pend_reg   <= pend_next;
            wallow_reg <= wallow_next;
            if (cfg_we)
            begin
                min_key_reg <= cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/cps_out_stage.sv
// ----------------------------------------------------------------------------
// cps_out_stage: acknowledgement register of the stager
// Holds one acknowledgement on the master stream until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_out_stage
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire cps_pkg::ack_t                  ack,
    output      logic                           out_free,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [cps_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned PAD_W = cps_pkg::M_TDATA_W - $bits(cps_pkg::ack_t);

    logic          valid_reg;
    logic          valid_next;
    cps_pkg::ack_t ack_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ack_reg <= ack;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, ack_reg};

endmodule

`default_nettype wire

>>> rtl/core/chunked_provision_stager.sv
// ----------------------------------------------------------------------------
// chunked_provision_stager: session receiver for chunked provisioning items
// Top level: input register, session decision stage, acknowledgement register.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the slave stream. s_tuser says whether a request is a
//   message header (0) or one data byte of the chunk just accepted (1).
//   Every header yields exactly one acknowledgement on the master stream;
//   data bytes yield none; they advance the write cursor and fill the port shadow.
//   Write min_key_length via cfg_we/cfg_wdata only while the block idles (not enforced).
// Timing:
//   A header is decided combinationally from the input register once the result
//   register is free; its ack is registered there. One request per cycle is
//   sustained while no header waits on the result register: the decision is one pass
//   over the registered fill levels between the input and result registers.
// Reset:
//   rst_n clears the session, all fill levels, the port shadow and the write
//   cursor, empties both registers, and sets min_key_length to 8.
// Back-pressure:
//   While m_tready is low the held acknowledgement stays; a pending header
//   waits in the input register and s_tready drops. Otherwise data bytes flow.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_provision_stager
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_we,
    input  wire logic [cps_pkg::KEYLEN_W-1:0]  cfg_wdata,  // min_key_length

    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // s_tdata from bit 0: item_id[7:0], generation[15:8], offset[31:16],
    // data_len[47:32], data_byte[55:48], format_ok[56], on_wifi[57],
    // flash_ok[58], crypto_ok[59], zero fill[63:60]
    input  wire logic [cps_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: action (0 header, 1 data byte)
    input  wire logic                           s_tuser,

    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata from bit 0: ack_item[7:0], ack_generation[15:8],
    // ack_status[18:16], next_offset[30:19], store_request[32:31],
    // zero fill[39:33]
    output      logic [cps_pkg::M_TDATA_W-1:0] m_tdata
);

    logic              req_valid;
    cps_pkg::request_t req;
    logic              advance;
    logic              out_free;
    logic              ack_valid;
    cps_pkg::ack_t     ack;

    // Advance a held request: data bytes always, headers only when the
    // result register can take the acknowledgement.
    assign advance = req_valid && ((req.action == cps_pkg::ACT_DATA) || out_free);

    cps_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    cps_session u_session
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .req       (req),
        .ack_valid (ack_valid),
        .ack       (ack)
    );

    cps_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ack_valid),
        .ack      (ack),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
